/* sv/vra_pkg.sv */
// Shared types and constants for the value rank assigner.
`default_nettype none
package vra_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned POS_W         = 6;
  localparam int unsigned RANK_W        = 7;

  // Flipping the sign bit makes unsigned order equal signed order.
  localparam logic [DATA_W-1:0] SIGN_FLIP = 32'h8000_0000;

  typedef enum logic [2:0] {
    S_LOAD,
    S_FETCH,
    S_CAPT,
    S_SCAN,
    S_WRBACK,
    S_EMIT
  } state_e;

  // Memory port strobes from the sequencer to the value store.
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage
`default_nettype wire

/* sv/value_rank_assigner_unit.sv */
// Top level of the value rank assigner: value store plus sequencer.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_ready_o | value_i, last_i
//   out     | output    | out_valid_o/out_ready_i | position_o, rank_out_o, overflow_o,
//           |           |                         | final_res_o
//
// Loading accepts one transaction per cycle. After the last one, a first pass marks
// first occurrences and a second pass, emit step included, counts smaller values for
// each entry; both passes read the value memory through its single read port.
// Reset clears the sequencer, count and flags; the memory is not cleared.
// A stalled output holds the sequencer in its emit step.
`default_nettype none
module value_rank_assigner_unit
  import vra_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic                     last_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic             [POS_W-1:0]  position_o,
  output logic             [RANK_W-1:0] rank_out_o,
  output logic                          overflow_o,
  output logic                          final_res_o
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  mem_ctl_t        mem_ctl;
  logic [AW-1:0]   mem_waddr;
  logic [DATA_W:0] mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic [DATA_W:0] mem_rdata;

  vra_store #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  vra_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .position_o  (position_o),
    .rank_out_o  (rank_out_o),
    .overflow_o  (overflow_o),
    .final_res_o (final_res_o),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

`ifndef SYNTHESIS
  // Loads and write-backs never share a cycle with a read.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl.we && mem_ctl.re))
    else $error("memory read and write in the same cycle");

  // The last transaction starts ranking and closes the input.
  a_last_closes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_i) |=> !in_ready_o)
    else $error("input still open after last transaction");

  // No input is taken while a run is still being emitted.
  a_no_load_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !final_res_o) |-> !in_ready_o)
    else $error("input accepted during emission");
`endif

endmodule
`default_nettype wire

/* sv/vra_store.sv */
// Value store: one write port and one registered read port.
`default_nettype none
module vra_store
  import vra_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_ITEMS_DEF,
  parameter int unsigned AW    = 6
) (
  input  wire logic           clk_i,
  input  wire mem_ctl_t       ctl_i,
  input  wire logic [AW-1:0]  waddr_i,
  input  wire logic [DATA_W:0] wdata_i,
  input  wire logic [AW-1:0]  raddr_i,
  output logic      [DATA_W:0] rdata_o
);

  // Each word holds the first-occurrence flag over the biased value.
  logic [DATA_W:0] mem [DEPTH];
  logic [DATA_W:0] rdata_q;

  // Write and read the array.
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* sv/vra_ctrl.sv */
// Sequencer: loads items, marks first occurrences, counts ranks, drives results.
`default_nettype none
module vra_ctrl
  import vra_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF,
  parameter int unsigned AW        = 6,
  parameter int unsigned CW        = 7
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic                     last_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic             [POS_W-1:0]  position_o,
  output logic             [RANK_W-1:0] rank_out_o,
  output logic                          overflow_o,
  output logic                          final_res_o,
  output mem_ctl_t                      mem_ctl_o,
  output logic             [AW-1:0]     mem_waddr_o,
  output logic             [DATA_W:0]   mem_wdata_o,
  output logic             [AW-1:0]     mem_raddr_o,
  input  wire logic        [DATA_W:0]   mem_rdata_i
);

  state_e state_q, state_d;

  logic [CW-1:0]     cnt_q;
  logic              ovf_q;
  logic              pend_q;
  logic              out_valid_q;
  logic [CW-1:0]     n_q;
  logic              run_ovf_q;
  logic [AW-1:0]     i_q;
  logic [CW-1:0]     j_q;
  logic              pass2_q;
  logic [DATA_W-1:0] cur_q;
  logic              cur_first_q;
  logic              hit_q;
  logic [CW-1:0]     rank_cnt_q;
  logic [POS_W-1:0]  position_q;
  logic [RANK_W-1:0] rank_q;
  logic              out_ovf_q;
  logic              final_q;

  logic              in_fire;
  logic              has_room;
  logic [CW-1:0]     limit;
  logic              scan_issue;
  logic              scan_done;
  logic              last_pos;
  logic              out_free;
  logic [DATA_W-1:0] rd_val;
  logic              rd_first;
  logic [CW-1:0]     rank_val;

  // Decode the common conditions.
  assign in_fire    = in_valid_i && in_ready_o;
  assign has_room   = cnt_q < CW'(MAX_ITEMS);
  assign limit      = pass2_q ? n_q : CW'(i_q);
  assign scan_issue = (state_q == S_SCAN) && (j_q < limit);
  assign scan_done  = (state_q == S_SCAN) && (j_q == limit) && !pend_q;
  assign last_pos   = (CW'(i_q) + CW'(1)) == n_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign rd_val     = mem_rdata_i[DATA_W-1:0];
  assign rd_first   = mem_rdata_i[DATA_W];
  assign rank_val   = cur_first_q ? (rank_cnt_q + CW'(1)) : '0;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_fire && last_i) state_d = S_FETCH;
      end
      S_FETCH:  state_d = S_CAPT;
      S_CAPT:   state_d = S_SCAN;
      S_SCAN: begin
        if (scan_done) state_d = pass2_q ? S_EMIT : S_WRBACK;
      end
      S_WRBACK: state_d = S_FETCH;
      S_EMIT: begin
        if (out_free) state_d = last_pos ? S_LOAD : S_FETCH;
      end
      default:  state_d = S_LOAD;
    endcase
  end

  // Drive handshake and memory port.
  always_comb begin
    in_ready_o   = 1'b0;
    mem_ctl_o.we = 1'b0;
    mem_ctl_o.re = 1'b0;
    mem_waddr_o  = cnt_q[AW-1:0];
    mem_wdata_o  = {1'b0, $unsigned(value_i) ^ SIGN_FLIP};
    mem_raddr_o  = j_q[AW-1:0];
    unique case (state_q)
      S_LOAD: begin
        in_ready_o   = 1'b1;
        mem_ctl_o.we = in_valid_i && has_room;
      end
      S_FETCH: begin
        mem_ctl_o.re = 1'b1;
        mem_raddr_o  = i_q;
      end
      S_SCAN: begin
        mem_ctl_o.re = scan_issue;
      end
      S_WRBACK: begin
        mem_ctl_o.we = 1'b1;
        mem_waddr_o  = i_q;
        mem_wdata_o  = {!hit_q, cur_q};
      end
      S_CAPT, S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= scan_issue;
      // Count stored items, flag drops, restart on the last transaction.
      if (in_fire) begin
        if (last_i) begin
          cnt_q <= '0;
          ovf_q <= 1'b0;
        end else if (has_room) begin
          cnt_q <= cnt_q + CW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      // Hold a result until it is taken.
      if ((state_q == S_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_LOAD: begin
        if (in_fire && last_i) begin
          n_q       <= has_room ? (cnt_q + CW'(1)) : cnt_q;
          run_ovf_q <= ovf_q || !has_room;
          i_q       <= '0;
          pass2_q   <= 1'b0;
        end
      end
      S_CAPT: begin
        cur_q       <= rd_val;
        cur_first_q <= rd_first;
        j_q         <= '0;
        hit_q       <= 1'b0;
        rank_cnt_q  <= '0;
      end
      S_SCAN: begin
        if (scan_issue) j_q <= j_q + CW'(1);
        // Compare the word returned for the previous address.
        if (pend_q) begin
          if (pass2_q) begin
            if (rd_first && (rd_val < cur_q)) rank_cnt_q <= rank_cnt_q + CW'(1);
          end else if (rd_val == cur_q) begin
            hit_q <= 1'b1;
          end
        end
      end
      S_WRBACK: begin
        if (last_pos) begin
          i_q     <= '0;
          pass2_q <= 1'b1;
        end else begin
          i_q <= i_q + AW'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          position_q <= POS_W'(i_q);
          rank_q     <= RANK_W'(rank_val);
          out_ovf_q  <= run_ovf_q;
          final_q    <= last_pos;
          i_q        <= i_q + AW'(1);
        end
      end
      S_FETCH: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = position_q;
  assign rank_out_o  = rank_q;
  assign overflow_o  = out_ovf_q;
  assign final_res_o = final_q;

endmodule
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for value_rank_assigner_unit: queued stimulus, rank predictor, checks.
`default_nettype none
module testbench
  import vra_pkg::*;
();

  localparam int CAPACITY   = MAX_ITEMS_DEF;
  localparam int ITEM_GOAL  = 260;
  localparam int LONG_HOLD  = 400;
  localparam int TAIL_WAIT  = 80;
  localparam int LIMIT_CYC  = 600000;

  // Value sources for a run of items
  localparam int SRC_WIDE    = 0;
  localparam int SRC_NARROW  = 1;
  localparam int SRC_EXTREME = 2;
  localparam int SRC_MIXED   = 3;

  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_ZERO = 32'h0000_0000;
  localparam logic [DATA_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic              drain;
  } pend_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [RANK_W-1:0] rank;
    logic              ovf;
    logic              fin;
  } rank_res_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     last_i      = 1'b0;
  logic                     out_ready_i = 1'b0;
  logic                     in_ready_o;
  logic                     out_valid_o;
  logic        [POS_W-1:0]  position_o;
  logic        [RANK_W-1:0] rank_out_o;
  logic                     overflow_o;
  logic                     final_res_o;

  value_rank_assigner_unit #(.MAX_ITEMS(CAPACITY)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .position_o  (position_o),
    .rank_out_o  (rank_out_o),
    .overflow_o  (overflow_o),
    .final_res_o (final_res_o)
  );

  always #6 clk_i = ~clk_i;

  pend_item_t        pending_items[$];
  rank_res_t         rank_expect_q[$];
  logic [DATA_W-1:0] held_vals[CAPACITY];
  int                held_count   = 0;
  logic              dropped_flag = 1'b0;

  int n_total      = 0;
  int n_accepted   = 0;
  int n_checked    = 0;
  int n_errors     = 0;
  int n_runs       = 0;
  int n_ovf_runs   = 0;
  int longest_run  = 0;
  bit in_taken     = 1'b0;
  bit out_taken    = 1'b0;

  // Queue one item for the driver
  task automatic push_item(input logic [DATA_W-1:0] v, input logic lst, input logic drn);
    pend_item_t p;
    p.value = v;
    p.last  = lst;
    p.drain = drn;
    pending_items.push_back(p);
  endtask

  function automatic logic [DATA_W-1:0] pick_value(input int src);
    int sel;
    sel = src;
    if (src == SRC_MIXED) sel = $urandom_range(SRC_WIDE, SRC_EXTREME);
    case (sel)
      SRC_WIDE:   return $urandom;
      SRC_NARROW: return DATA_W'($signed($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 6))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return VAL_ZERO;
          3:       return VAL_NEG1;
          4:       return 32'h0000_0001;
          5:       return VAL_MIN + 1;
          default: return VAL_MAX - 1;
        endcase
      end
    endcase
  endfunction

  // Queue a complete run ending in a last item
  task automatic push_run(input int len, input int src, input logic drn);
    int k;
    for (k = 0; k < len; k++) begin
      push_item(pick_value(src), k == len - 1, drn && k == 0);
    end
  endtask

  // Idle draw shared by both sides: 0..19, with occasional stretches of no idling
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Store the item; on last, compute the rank of every stored position
  task automatic predict_ranks(input logic [DATA_W-1:0] v, input logic lst);
    bit        first_occ[CAPACITY];
    rank_res_t r;
    int        i, j, rank;
    if (held_count < CAPACITY) begin
      held_vals[held_count] = v;
      held_count++;
    end else begin
      dropped_flag = 1'b1;
    end
    if (lst) begin
      for (i = 0; i < held_count; i++) begin
        first_occ[i] = 1'b1;
        for (j = 0; j < i; j++) begin
          if (held_vals[j] == held_vals[i]) first_occ[i] = 1'b0;
        end
      end
      for (i = 0; i < held_count; i++) begin
        rank = 0;
        if (first_occ[i]) begin
          rank = 1;
          for (j = 0; j < held_count; j++) begin
            if (first_occ[j] && $signed(held_vals[j]) < $signed(held_vals[i])) rank++;
          end
        end
        r.pos  = POS_W'(i);
        r.rank = RANK_W'(rank);
        r.ovf  = dropped_flag;
        r.fin  = (i == held_count - 1);
        rank_expect_q.push_back(r);
      end
      n_runs++;
      if (dropped_flag) n_ovf_runs++;
      if (held_count > longest_run) longest_run = held_count;
      held_count   = 0;
      dropped_flag = 1'b0;
    end
  endtask

  // Sample input transactions and feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_ranks(value_i, last_i);
      n_accepted++;
      in_taken = 1'b1;
    end
  end

  // Check each output transaction against the oldest expectation
  always @(posedge clk_i) begin : rank_check
    rank_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      out_taken = 1'b1;
      if (rank_expect_q.size() == 0) begin
        $display("%0t: unexpected result, position %0d rank %0d", $time, position_o,
                 rank_out_o);
        n_errors++;
      end else begin
        want = rank_expect_q.pop_front();
        n_checked++;
        if (position_o !== want.pos) begin
          $display("%0t: position expected %0d, got %0d", $time, want.pos, position_o);
          n_errors++;
        end
        if (rank_out_o !== want.rank) begin
          $display("%0t: rank_out at position %0d expected %0d, got %0d", $time, want.pos,
                   want.rank, rank_out_o);
          n_errors++;
        end
        if (overflow_o !== want.ovf) begin
          $display("%0t: overflow at position %0d expected %0b, got %0b", $time, want.pos,
                   want.ovf, overflow_o);
          n_errors++;
        end
        if (final_res_o !== want.fin) begin
          $display("%0t: final_res at position %0d expected %0b, got %0b", $time, want.pos,
                   want.fin, final_res_o);
          n_errors++;
        end
      end
    end
  end

  // Drive input transactions from the pending queue
  int tx_gap   = 0;
  int tx_burst = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      // hold the offered item until it is taken
    end else begin
      if (in_taken) begin
        in_taken = 1'b0;
        void'(pending_items.pop_front());
        tx_gap = draw_wait(tx_burst);
      end
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0 &&
                   !(pending_items[0].drain && rank_expect_q.size() != 0)) begin
        in_valid_i <= 1'b1;
        value_i    <= pending_items[0].value;
        last_i     <= pending_items[0].last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Drive out_ready: random stalls per result, plus one long hold-off
  int  rx_wait   = 0;
  int  rx_burst  = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken = 1'b0;
        rx_wait = draw_wait(rx_burst);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && n_checked >= 60 && out_valid_o) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (rx_wait > 0) begin
        if (out_valid_o) rx_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stop a hung run
  initial begin
    #(12 * LIMIT_CYC);
    $display("value_rank_assigner_unit verification failed");
    $finish;
  end

  initial begin
    bit did_full, did_ovf;
    did_full = 1'b0;
    did_ovf  = 1'b0;

    // Directed: single extreme item
    push_item(VAL_MAX, 1'b1, 1'b0);
    // Directed: both extremes, zero, minus one, one
    push_item(VAL_MIN, 1'b0, 1'b0);
    push_item(VAL_MAX, 1'b0, 1'b0);
    push_item(VAL_ZERO, 1'b0, 1'b0);
    push_item(VAL_NEG1, 1'b0, 1'b0);
    push_item(32'h0000_0001, 1'b1, 1'b0);
    // Directed: repeats of equal values, sender waits for the previous run
    push_item(32'd7, 1'b0, 1'b1);
    push_item(32'd7, 1'b0, 1'b0);
    push_item(-32'sd3, 1'b0, 1'b0);
    push_item(32'd7, 1'b0, 1'b0);
    push_item(-32'sd3, 1'b0, 1'b0);
    push_item(32'd100, 1'b1, 1'b0);
    // Directed: descending order
    push_item(32'd3, 1'b0, 1'b0);
    push_item(32'd2, 1'b0, 1'b0);
    push_item(32'd1, 1'b0, 1'b0);
    push_item(VAL_ZERO, 1'b1, 1'b0);
    // Directed: all values equal at the minimum
    push_item(VAL_MIN, 1'b0, 1'b0);
    push_item(VAL_MIN, 1'b0, 1'b0);
    push_item(VAL_MIN, 1'b1, 1'b0);

    // Random runs, mostly short, with one full store and one overflowing run
    while (pending_items.size() < ITEM_GOAL) begin
      if (!did_full && pending_items.size() >= 100) begin
        did_full = 1'b1;
        push_run(CAPACITY, SRC_WIDE, 1'b1);
      end else if (!did_ovf && pending_items.size() >= 180) begin
        did_ovf = 1'b1;
        push_run(CAPACITY + 2, SRC_MIXED, 1'b0);
      end else begin
        push_run($urandom_range(1, 8), $urandom_range(SRC_WIDE, SRC_MIXED),
                 $urandom_range(0, 5) == 0);
      end
    end
    n_total = pending_items.size();

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_total || rank_expect_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("Covered %0d runs from %0d items, %0d ranks checked, longest run %0d stored,",
             n_runs, n_accepted, n_checked, longest_run);
    $display("%0d runs with dropped items; extremes, repeats and a long output stall included.",
             n_ovf_runs);
    if (n_errors == 0) begin
      $display("value_rank_assigner_unit verification clean");
    end else begin
      $display("value_rank_assigner_unit verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
sv/vra_pkg.sv
sv/vra_store.sv
sv/vra_ctrl.sv
sv/value_rank_assigner_unit.sv
test/testbench.sv
